// ===== hdl/blx_pkg.sv =====
// ----------------------------------------------------------------------------
// blx_pkg - shared types for the bitwise expression lexer
// Token and error codes, scanner modes and the bundle of tokens that one
// character produces on its way from the scanner to the serialiser.
// ----------------------------------------------------------------------------
package blx_pkg;

    // a single character gives at most three tokens
    localparam int MAX_TOK = 3;

    typedef enum logic [3:0] {
        TK_INT    = 4'd0,
        TK_OR     = 4'd1,
        TK_AND    = 4'd2,
        TK_NOT    = 4'd3,
        TK_LPAREN = 4'd4,
        TK_RPAREN = 4'd5,
        TK_SEMI   = 4'd6,
        TK_SHL    = 4'd7,
        TK_SHR    = 4'd8,
        TK_END    = 4'd9,
        TK_ERROR  = 4'd10
    } tok_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_CHAR = 2'd1,
        ERR_OVF  = 2'd2,
        ERR_OP   = 2'd3
    } err_kind_t;

    typedef enum logic [1:0] {
        SCAN_IDLE = 2'd0,
        SCAN_NUM  = 2'd1,
        SCAN_LT   = 2'd2,
        SCAN_GT   = 2'd3
    } scan_mode_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [31:0] value;
        err_kind_t   err;
        logic [7:0]  bad;
    } tok_t;

    typedef struct packed {
        logic [1:0]             count;
        tok_t [MAX_TOK-1:0]     toks;
    } bundle_t;

endpackage

// ===== hdl/blx_char_if.sv =====
// ----------------------------------------------------------------------------
// blx_char_if - character request channel
// One ASCII byte per request, with a flag marking the final byte of a text.
// ----------------------------------------------------------------------------
interface blx_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_text;

    modport source (output valid, char_byte, end_of_text, input ready);
    modport sink   (input valid, char_byte, end_of_text, output ready);
endinterface

// ===== hdl/blx_tok_if.sv =====
// ----------------------------------------------------------------------------
// blx_tok_if - token request channel
// One token per request: kind, literal value, error detail and run marker.
// ----------------------------------------------------------------------------
interface blx_tok_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [31:0] literal_value;
    logic [1:0]  error_kind;
    logic [7:0]  bad_char;
    logic        last_of_run;

    modport source (output valid, token_kind, literal_value, error_kind, bad_char,
                    last_of_run, input ready);
    modport sink   (input valid, token_kind, literal_value, error_kind, bad_char,
                    last_of_run, output ready);
endinterface

// ===== hdl/bitwise_expression_lexer.sv =====
// ----------------------------------------------------------------------------
// bitwise_expression_lexer - streaming lexer for bitwise expressions
// Turns a character stream into literal, operator, END and error tokens.
// ----------------------------------------------------------------------------
// Usage:
//   chars  : one ASCII byte per request, end_of_text on the final byte. A
//            zero byte also ends the text; it is not scanned itself.
//   tokens : one token per request. Each character yields zero to three
//            tokens; last_of_run marks the final token caused by a character.
// Path: a character's tokens are written into the queue, then loaded into the
//   serialiser's current bundle register and from there into the output register.
// Throughput: one character per cycle while tokens drain; the output port
//   moves one token per cycle, so that port sets the sustained rate when
//   characters cause more than one token each.
// Reset: scanner returns to idle with an empty accumulator, the queue and
//   the output stage are emptied. No clearing pass is needed.
// Stall: a stalled receiver holds the output register; the serialiser and
//   QUEUE_DEPTH bundles keep absorbing characters, after which chars.ready
//   drops until the queue has room again.
// ----------------------------------------------------------------------------
module bitwise_expression_lexer
    import blx_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    blx_char_if.sink    chars,
    blx_tok_if.source   tokens
);

    // scanner to queue
    logic    push;
    bundle_t push_data;
    logic    full;

    // queue to serialiser
    logic    pop;
    bundle_t pop_data;
    logic    empty;

    // front: classify each character and build its token bundle
    blx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    // decouple scanning from delivery so each side stalls on its own
    blx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // back: hand out the tokens of each bundle in order
    blx_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop      (pop),
        .pop_data (pop_data),
        .empty    (empty),
        .tokens   (tokens)
    );

endmodule

// ===== hdl/blx_front.sv =====
// ----------------------------------------------------------------------------
// blx_front - character scanner
// Classifies each character against the scanner mode, updates the literal
// accumulator and packs the tokens it causes into one bundle for the queue.
// ----------------------------------------------------------------------------
module blx_front
    import blx_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    blx_char_if.sink        chars,
    output logic            push,
    output bundle_t         push_data,
    input  logic            full
);

    localparam int NUM_CAND = 4;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_AND    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CH_OR     = 8'h7C;
    localparam logic [7:0] CH_NOT    = 8'h7E;

    function automatic tok_t mk_tok(tok_kind_t k, logic [31:0] v, err_kind_t e,
                                    logic [7:0] b);
        tok_t t;
        t.kind  = k;
        t.value = v;
        t.err   = e;
        t.bad   = b;
        return t;
    endfunction

    function automatic tok_t num_tok(logic [31:0] acc, logic ovf);
        tok_t t;
        if (ovf)
            t = mk_tok(TK_ERROR, 32'd0, ERR_OVF, 8'd0);
        else
            t = mk_tok(TK_INT, acc, ERR_NONE, 8'd0);
        return t;
    endfunction

    scan_mode_t  mode_reg, mode_next, mode_m;
    logic [31:0] acc_reg, acc_next, acc_m;
    logic        ovf_reg, ovf_next, ovf_m;

    logic [7:0]  ch;
    logic [3:0]  digit;
    logic        accept, flush, do_idle;
    logic        is_nul, is_digit, is_alpha, is_space;
    logic [35:0] acc_x10;

    tok_t                cand [NUM_CAND];
    logic [NUM_CAND-1:0] cand_valid;
    logic [1:0]          slot;
    bundle_t             bundle;

    assign ch          = chars.char_byte;
    assign digit       = ch[3:0];
    assign chars.ready = !full;
    assign accept      = chars.valid && !full;

    assign is_nul   = (ch == CH_NUL);
    assign is_digit = (ch >= CH_0) && (ch <= CH_9);
    assign is_alpha = ((ch >= CH_UC_A) && (ch <= CH_UC_Z)) ||
                      ((ch >= CH_LC_A) && (ch <= CH_LC_Z));
    assign is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    assign flush    = is_nul || chars.end_of_text;

    // acc * 10 + digit as two shifted adds; upper nibble flags overflow
    assign acc_x10 = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + {32'd0, digit};

    // mode after the character itself, before any end-of-text flush
    always_comb
    begin
        mode_m  = mode_reg;
        acc_m   = acc_reg;
        ovf_m   = ovf_reg;
        do_idle = 1'b0;
        if (!is_nul)
        begin
            unique case (mode_reg)
                SCAN_NUM:
                begin
                    if (is_digit)
                    begin
                        acc_m = acc_x10[31:0];
                        ovf_m = ovf_reg | (acc_x10[35:32] != 4'd0);
                    end
                    else
                        do_idle = 1'b1;
                end
                SCAN_LT:
                begin
                    mode_m  = SCAN_IDLE;
                    do_idle = (ch != CH_LT);
                end
                SCAN_GT:
                begin
                    mode_m  = SCAN_IDLE;
                    do_idle = (ch != CH_GT);
                end
                SCAN_IDLE:
                    do_idle = 1'b1;
            endcase
            if (do_idle)
            begin
                mode_m = SCAN_IDLE;
                if (is_digit)
                begin
                    mode_m = SCAN_NUM;
                    acc_m  = {28'd0, digit};
                    ovf_m  = 1'b0;
                end
                else if (ch == CH_LT)
                    mode_m = SCAN_LT;
                else if (ch == CH_GT)
                    mode_m = SCAN_GT;
            end
        end
    end

    // next state: a flush returns everything to idle
    always_comb
    begin
        if (flush)
        begin
            mode_next = SCAN_IDLE;
            acc_next  = 32'd0;
            ovf_next  = 1'b0;
        end
        else
        begin
            mode_next = mode_m;
            acc_next  = acc_m;
            ovf_next  = ovf_m;
        end
    end

    // candidate tokens in emission order
    always_comb
    begin
        // token closing the pending construct
        cand_valid[0] = 1'b0;
        cand[0]       = mk_tok(TK_ERROR, 32'd0, ERR_OP, 8'd0);
        if (!is_nul)
        begin
            unique case (mode_reg)
                SCAN_NUM:
                begin
                    cand_valid[0] = !is_digit;
                    if (is_alpha)
                        cand[0] = mk_tok(TK_ERROR, 32'd0, ERR_CHAR, ch);
                    else
                        cand[0] = num_tok(acc_reg, ovf_reg);
                end
                SCAN_LT:
                begin
                    cand_valid[0] = 1'b1;
                    if (ch == CH_LT)
                        cand[0] = mk_tok(TK_SHL, 32'd0, ERR_NONE, 8'd0);
                end
                SCAN_GT:
                begin
                    cand_valid[0] = 1'b1;
                    if (ch == CH_GT)
                        cand[0] = mk_tok(TK_SHR, 32'd0, ERR_NONE, 8'd0);
                end
                SCAN_IDLE:
                    cand_valid[0] = 1'b0;
            endcase
        end

        // single-character token from a fresh scan
        cand_valid[1] = do_idle && !is_space && !is_digit && (ch != CH_LT) &&
                        (ch != CH_GT);
        unique case (ch)
            CH_OR:     cand[1] = mk_tok(TK_OR, 32'd0, ERR_NONE, 8'd0);
            CH_AND:    cand[1] = mk_tok(TK_AND, 32'd0, ERR_NONE, 8'd0);
            CH_NOT:    cand[1] = mk_tok(TK_NOT, 32'd0, ERR_NONE, 8'd0);
            CH_LPAREN: cand[1] = mk_tok(TK_LPAREN, 32'd0, ERR_NONE, 8'd0);
            CH_RPAREN: cand[1] = mk_tok(TK_RPAREN, 32'd0, ERR_NONE, 8'd0);
            CH_SEMI:   cand[1] = mk_tok(TK_SEMI, 32'd0, ERR_NONE, 8'd0);
            default:   cand[1] = mk_tok(TK_ERROR, 32'd0, ERR_CHAR, ch);
        endcase

        // flush of whatever is still pending
        cand_valid[2] = flush && (mode_m != SCAN_IDLE);
        if (mode_m == SCAN_NUM)
            cand[2] = num_tok(acc_m, ovf_m);
        else
            cand[2] = mk_tok(TK_ERROR, 32'd0, ERR_OP, 8'd0);

        cand_valid[3] = flush;
        cand[3]       = mk_tok(TK_END, 32'd0, ERR_NONE, 8'd0);
    end

    // pack valid candidates into consecutive slots
    always_comb
    begin
        slot   = 2'd0;
        bundle = '0;
        for (int i = 0; i < NUM_CAND; i++)
        begin
            if (cand_valid[i])
            begin
                if (slot != 2'(MAX_TOK))
                    bundle.toks[slot] = cand[i];
                slot = slot + 2'd1;
            end
        end
        bundle.count = slot;
    end

    assign push      = accept && (bundle.count != 2'd0);
    assign push_data = bundle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= SCAN_IDLE;
            acc_reg  <= 32'd0;
            ovf_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            ovf_reg  <= ovf_next;
        end
    end

    a_flush_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && flush |=> mode_reg == SCAN_IDLE && !ovf_reg)
        else $error("scanner not idle after end of text");

endmodule

// ===== hdl/blx_queue.sv =====
// ----------------------------------------------------------------------------
// blx_queue - token bundle queue
// Short first-in first-out store between scanner and serialiser.
// ----------------------------------------------------------------------------
module blx_queue
    import blx_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    input  logic    pop,
    output bundle_t pop_data,
    output logic    empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bundle_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("bundle pushed into full queue");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("bundle popped from empty queue");

endmodule

// ===== hdl/blx_back.sv =====
// ----------------------------------------------------------------------------
// blx_back - token serialiser
// Takes one bundle at a time from the queue and hands its tokens out one per
// request through a registered output stage.
// ----------------------------------------------------------------------------
module blx_back
    import blx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    output logic        pop,
    input  bundle_t     pop_data,
    input  logic        empty,
    blx_tok_if.source   tokens
);

    logic       cur_valid_reg, cur_valid_next;
    bundle_t    cur_reg, cur_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    tok_t       out_tok_reg, out_tok_next;
    logic       out_last_reg, out_last_next;

    logic       out_free, send, cur_last;

    assign out_free = !out_valid_reg || tokens.ready;
    assign send     = cur_valid_reg && out_free;
    assign cur_last = (idx_reg == cur_reg.count - 2'd1);
    assign pop      = !empty && (!cur_valid_reg || (send && cur_last));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_tok_next   = out_tok_reg;
        out_last_next  = out_last_reg;
        idx_next       = idx_reg;
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        if (send)
        begin
            out_valid_next = 1'b1;
            out_tok_next   = cur_reg.toks[idx_reg];
            out_last_next  = cur_last;
            idx_next       = idx_reg + 2'd1;
        end
        else if (tokens.ready)
            out_valid_next = 1'b0;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            cur_next       = pop_data;
            idx_next       = 2'd0;
        end
        else if (send && cur_last)
            cur_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_tok_reg  <= out_tok_next;
        out_last_reg <= out_last_next;
    end

    assign tokens.valid         = out_valid_reg;
    assign tokens.token_kind    = out_tok_reg.kind;
    assign tokens.literal_value = out_tok_reg.value;
    assign tokens.error_kind    = out_tok_reg.err;
    assign tokens.bad_char      = out_tok_reg.bad;
    assign tokens.last_of_run   = out_last_reg;

    a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> cur_reg.count != 2'd0 && idx_reg < cur_reg.count)
        else $error("serialiser index outside current bundle");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_tok_reg.kind == TK_END |-> out_last_reg)
        else $error("END token not marked as last of run");

endmodule
